[rtl/ptt_pkg.sv]
package ptt_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FOLD,
      ST_DIFF,
      ST_SCALE,
      ST_CMP,
      ST_DONE
   } ptt_state_type;

   // what a product is used for when it comes back from the multiplier
   typedef enum logic [1:0] {
      OP_MINOR_SET,
      OP_MINOR_SUB,
      OP_ROW_LO,
      OP_ROW_HI
   } ptt_op_type;

   localparam int unsigned NUM_VERT    = 4;
   localparam int unsigned NUM_AXIS    = 3;
   localparam int unsigned RSP_TDATA_W = 8;

   // volume index: 0 is the full tetrahedron, 1..4 put the point in place of a vertex
   localparam logic [2:0] DET_FULL = 3'd0;
   localparam logic [2:0] DET_LAST = 3'd4;

   // twelve products per volume, five shift-add steps for the x10000 scale
   localparam logic [3:0] OP_LAST  = 4'd11;
   localparam logic [3:0] TOL_LAST = 4'd4;

   typedef struct packed {
      ptt_op_type kind;
      logic [1:0] row;
   } ptt_tag_type;

   // sequencer to datapath
   typedef struct packed {
      logic        idle;
      logic        edge_load;
      logic [2:0]  det;
      logic        issue;
      ptt_tag_type tag;
      logic        fold;
      logic        diff_load;
      logic        scale_en;
      logic [2:0]  scale_sel;
      logic        cmp_load;
      logic        publish;
   } ptt_ctl_type;

   // datapath to sequencer
   typedef struct packed {
      logic full_zero;
      logic out_free;
   } ptt_stat_type;

   // product order for one volume: both minor products of each row, then the
   // low and high halves of each minor times the first edge component
   function automatic ptt_tag_type ptt_op_decode(input logic [3:0] idx);
      ptt_tag_type t;
      unique case (idx)
         4'd0:    t = '{kind: OP_MINOR_SET, row: 2'd0};
         4'd1:    t = '{kind: OP_MINOR_SUB, row: 2'd0};
         4'd2:    t = '{kind: OP_MINOR_SET, row: 2'd1};
         4'd3:    t = '{kind: OP_MINOR_SUB, row: 2'd1};
         4'd4:    t = '{kind: OP_MINOR_SET, row: 2'd2};
         4'd5:    t = '{kind: OP_MINOR_SUB, row: 2'd2};
         4'd6:    t = '{kind: OP_ROW_LO,    row: 2'd0};
         4'd7:    t = '{kind: OP_ROW_HI,    row: 2'd0};
         4'd8:    t = '{kind: OP_ROW_LO,    row: 2'd1};
         4'd9:    t = '{kind: OP_ROW_HI,    row: 2'd1};
         4'd10:   t = '{kind: OP_ROW_LO,    row: 2'd2};
         4'd11:   t = '{kind: OP_ROW_HI,    row: 2'd2};
         default: t = '{kind: OP_MINOR_SET, row: 2'd0};
      endcase
      return t;
   endfunction

   // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
   function automatic logic [3:0] ptt_tol_shift(input logic [2:0] k);
      logic [3:0] s;
      unique case (k)
         3'd0:    s = 4'd13;
         3'd1:    s = 4'd10;
         3'd2:    s = 4'd9;
         3'd3:    s = 4'd8;
         3'd4:    s = 4'd4;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

endpackage

[rtl/ptt_mul.sv]
module ptt_mul #(
   parameter int OP_W = 26
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       issue,
   input  ptt_pkg::ptt_tag_type       tag,
   input  logic signed [OP_W-1:0]     opa,
   input  logic signed [OP_W-1:0]     opb,
   output logic                       prod_vld,
   output ptt_pkg::ptt_tag_type       prod_tag,
   output logic signed [2*OP_W-1:0]   prod
);
   import ptt_pkg::*;

   localparam int PROD_W = 2 * OP_W;

   logic                     vld_ff;
   ptt_tag_type              tag_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // signed product, exact in the doubled width
   assign prod_in = PROD_W'(opa) * PROD_W'(opb);

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= issue;
      end
   end

   // product and its tag
   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff <= prod_in;
         tag_ff  <= tag;
      end
   end

   assign prod_vld = vld_ff;
   assign prod_tag = tag_ff;
   assign prod     = prod_ff;

endmodule

[rtl/ptt_ctrl.sv]
module ptt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  query_start,
   input  ptt_pkg::ptt_stat_type stat,
   output ptt_pkg::ptt_ctl_type  ctl
);
   import ptt_pkg::*;

   ptt_state_type state_ff, state_in;
   logic [2:0]    det_ff, det_in;
   logic [3:0]    cnt_ff, cnt_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         det_ff   <= DET_FULL;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         det_ff   <= det_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and controls
   always_comb begin
      state_in      = state_ff;
      det_in        = det_ff;
      cnt_in        = cnt_ff;
      ctl           = '0;
      ctl.det       = det_ff;
      ctl.scale_sel = cnt_ff[2:0];
      unique case (state_ff)
         ST_IDLE: begin
            ctl.idle = 1'b1;
            if (query_start) begin
               det_in   = DET_FULL;
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            ctl.edge_load = 1'b1;
            cnt_in        = '0;
            state_in      = ST_ISSUE;
         end
         ST_ISSUE: begin
            ctl.issue = 1'b1;
            ctl.tag   = ptt_op_decode(cnt_ff);
            if (cnt_ff == OP_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            ctl.fold = 1'b1;
            if (det_ff == DET_FULL && stat.full_zero) begin
               state_in = ST_DONE;
            end else if (det_ff == DET_LAST) begin
               state_in = ST_DIFF;
            end else begin
               det_in   = det_ff + 3'd1;
               state_in = ST_EDGE;
            end
         end
         ST_DIFF: begin
            ctl.diff_load = 1'b1;
            cnt_in        = '0;
            state_in      = ST_SCALE;
         end
         ST_SCALE: begin
            ctl.scale_en = 1'b1;
            if (cnt_ff == TOL_LAST) begin
               state_in = ST_CMP;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_CMP: begin
            ctl.cmp_load = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               ctl.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a flat full volume ends the request at once
   a_degen_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD && det_ff == DET_FULL && stat.full_zero) |=> state_ff == ST_DONE)
      else $error("degenerate volume did not end the request");

   // volume index stays within the five volumes
   a_det_range: assert property (@(posedge clock) disable iff (reset)
      det_ff <= DET_LAST)
      else $error("volume index out of range");

   // scale loop stays within its five steps
   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCALE |-> cnt_ff <= TOL_LAST)
      else $error("scale step out of range");

endmodule

[rtl/point_in_tetrahedron_test.sv]
// Point-in-tetrahedron test. A request with tuser 0 loads one of four vertices
// (slot in tdata) and gives no response. A request with tuser 1 gives a query point
// and returns one response: inside_res is 1 when the sum of the four sub-volumes
// (the point put in place of each vertex in turn) is at most 1.0001 times the full
// volume, and degenerate is 1, with inside_res 0, when the full volume is zero. All
// volumes are exact integer determinants. A query occupies the block until its
// response is valid (a flat tetrahedron ends it after the first determinant): each
// of the five determinants takes an edge load, twelve products through the single
// (COORD_BITS+2)-bit signed multiplier, a drain and a fold, and the x10000 tolerance
// scale takes five shift-add steps. A finished response waits in an output register,
// so the next request is taken while the previous response is pending.
module point_in_tetrahedron_test #(
   parameter  int COORD_BITS  = 24,
   localparam int REQ_TDATA_W = ((2 + 3 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vertex_slot, coord_x, coord_y, coord_z
   input  logic [REQ_TDATA_W-1:0]             req_tdata,
   // req_type
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // inside_res, degenerate
   output logic [ptt_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import ptt_pkg::*;

   localparam int CW   = COORD_BITS;
   localparam int EW   = CW + 1;
   localparam int MW   = CW + 2;
   localparam int PW   = 2 * MW;
   localparam int MINW = 2 * CW + 3;
   localparam int AW   = 3 * CW + 6;
   localparam int SW   = AW + 2;
   localparam int DW   = SW + 1;
   localparam int TW   = SW + 14;

   ptt_ctl_type  ctl;
   ptt_stat_type stat;

   logic                 req_go;
   logic [1:0]           in_slot;
   logic signed [CW-1:0] in_coord [NUM_AXIS];

   logic signed [CW-1:0] vtx_ff [NUM_VERT][NUM_AXIS];
   logic signed [CW-1:0] pt_ff  [NUM_AXIS];
   logic signed [CW-1:0] corner [NUM_VERT][NUM_AXIS];

   logic signed [EW-1:0] e1_ff [NUM_AXIS];
   logic signed [EW-1:0] e2_ff [NUM_AXIS];
   logic signed [EW-1:0] e3_ff [NUM_AXIS];

   logic signed [EW-1:0]   ea2, eb3, ea3, eb2, e1s;
   logic signed [MINW-1:0] mnr;
   logic signed [MW-1:0]   opa, opb;

   logic                 prod_vld;
   ptt_tag_type          prod_tag;
   logic signed [PW-1:0] prod;

   logic signed [MINW-1:0] hold_ff;
   logic signed [MINW-1:0] minor_ff [NUM_AXIS];
   logic signed [AW-1:0]   acc_ff;

   logic          acc_neg, acc_zero;
   logic [AW-1:0] acc_mag;
   logic [SW-1:0] acc_ext;
   logic [AW-1:0] full_ff;
   logic [SW-1:0] sum_ff;
   logic [DW-1:0] diff_ff;
   logic          diff_pos;
   logic [TW-1:0] tacc_ff;

   logic res_inside_ff, res_degen_ff;
   logic rsp_valid_ff, rsp_inside_ff, rsp_degen_ff;

   // request fields
   assign req_tready  = ctl.idle;
   assign req_go      = req_tvalid & req_tready;
   assign in_slot     = req_tdata[1:0];
   assign in_coord[0] = req_tdata[2 +: CW];
   assign in_coord[1] = req_tdata[2 + CW +: CW];
   assign in_coord[2] = req_tdata[2 + 2 * CW +: CW];

   // vertex store, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < NUM_VERT; v++) begin
            for (int a = 0; a < NUM_AXIS; a++) begin
               vtx_ff[v][a] <= '0;
            end
         end
      end else if (req_go && !req_tuser) begin
         for (int a = 0; a < NUM_AXIS; a++) begin
            vtx_ff[in_slot][a] <= in_coord[a];
         end
      end
   end

   // query point
   always_ff @(posedge clock) begin
      if (req_go && req_tuser) begin
         pt_ff <= in_coord;
      end
   end

   // corners of the current volume: the point replaces vertex det-1
   always_comb begin
      for (int v = 0; v < NUM_VERT; v++) begin
         for (int a = 0; a < NUM_AXIS; a++) begin
            corner[v][a] = (ctl.det == 3'(v + 1)) ? pt_ff[a] : vtx_ff[v][a];
         end
      end
   end

   // edge vectors from the first corner
   always_ff @(posedge clock) begin
      if (ctl.edge_load) begin
         for (int a = 0; a < NUM_AXIS; a++) begin
            e1_ff[a] <= EW'(corner[1][a]) - EW'(corner[0][a]);
            e2_ff[a] <= EW'(corner[2][a]) - EW'(corner[0][a]);
            e3_ff[a] <= EW'(corner[3][a]) - EW'(corner[0][a]);
         end
      end
   end

   // per-row operands: row r uses axes (r+1, r+2) for its minor
   always_comb begin
      case (ctl.tag.row)
         2'd1: begin
            ea2 = e2_ff[2];
            eb3 = e3_ff[0];
            ea3 = e3_ff[2];
            eb2 = e2_ff[0];
            e1s = e1_ff[1];
            mnr = minor_ff[1];
         end
         2'd2: begin
            ea2 = e2_ff[0];
            eb3 = e3_ff[1];
            ea3 = e3_ff[0];
            eb2 = e2_ff[1];
            e1s = e1_ff[2];
            mnr = minor_ff[2];
         end
         default: begin
            ea2 = e2_ff[1];
            eb3 = e3_ff[2];
            ea3 = e3_ff[1];
            eb2 = e2_ff[2];
            e1s = e1_ff[0];
            mnr = minor_ff[0];
         end
      endcase
   end

   // multiplier operand select; wide minors go in as unsigned low and signed high halves
   always_comb begin
      case (ctl.tag.kind)
         OP_MINOR_SET: begin
            opa = MW'(ea2);
            opb = MW'(eb3);
         end
         OP_MINOR_SUB: begin
            opa = MW'(ea3);
            opb = MW'(eb2);
         end
         OP_ROW_LO: begin
            opa = $signed({1'b0, mnr[CW:0]});
            opb = MW'(e1s);
         end
         default: begin
            opa = mnr[MINW-1:CW+1];
            opb = MW'(e1s);
         end
      endcase
   end

   ptt_mul #(
      .OP_W (MW)
   ) u_mul (
      .clock    (clock),
      .reset    (reset),
      .issue    (ctl.issue),
      .tag      (ctl.tag),
      .opa      (opa),
      .opb      (opb),
      .prod_vld (prod_vld),
      .prod_tag (prod_tag),
      .prod     (prod)
   );

   // product write-back: minors and determinant accumulator
   always_ff @(posedge clock) begin
      if (ctl.edge_load) begin
         acc_ff <= '0;
      end else if (prod_vld) begin
         case (prod_tag.kind)
            OP_MINOR_SET: hold_ff <= prod[MINW-1:0];
            OP_MINOR_SUB: minor_ff[prod_tag.row] <= hold_ff - prod[MINW-1:0];
            OP_ROW_LO:    acc_ff <= acc_ff + AW'(prod);
            default:      acc_ff <= acc_ff + (AW'(prod) <<< (CW + 1));
         endcase
      end
   end

   // magnitude of the finished determinant
   assign acc_neg  = acc_ff[AW-1];
   assign acc_zero = (acc_ff == '0);
   assign acc_mag  = acc_neg ? AW'(-acc_ff) : acc_ff;
   assign acc_ext  = SW'(acc_ff);
   assign diff_pos = !diff_ff[DW-1] && (diff_ff != '0);

   // volume folding, tolerance scale and compare
   always_ff @(posedge clock) begin
      if (ctl.fold) begin
         if (ctl.det == DET_FULL) begin
            full_ff       <= acc_mag;
            sum_ff        <= '0;
            res_inside_ff <= 1'b0;
            res_degen_ff  <= acc_zero;
         end else if (acc_neg) begin
            sum_ff <= sum_ff - acc_ext;
         end else begin
            sum_ff <= sum_ff + acc_ext;
         end
      end
      if (ctl.diff_load) begin
         diff_ff <= DW'(sum_ff) - DW'(full_ff);
         tacc_ff <= '0;
      end
      if (ctl.scale_en) begin
         tacc_ff <= tacc_ff + (TW'(diff_ff[SW-1:0]) << ptt_tol_shift(ctl.scale_sel));
      end
      if (ctl.cmp_load) begin
         res_inside_ff <= !diff_pos || (tacc_ff <= TW'(full_ff));
         res_degen_ff  <= 1'b0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.publish) begin
         rsp_inside_ff <= res_inside_ff;
         rsp_degen_ff  <= res_degen_ff;
      end
   end

   assign stat.full_zero = acc_zero;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = RSP_TDATA_W'({rsp_degen_ff, rsp_inside_ff});

   ptt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .query_start (req_go & req_tuser),
      .stat        (stat),
      .ctl         (ctl)
   );

   // no product is in flight while the block takes requests
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !prod_vld)
      else $error("product in flight while idle");

   // every product comes from an issue in the previous cycle
   a_mul_latency: assert property (@(posedge clock) disable iff (reset)
      prod_vld |-> $past(ctl.issue))
      else $error("product without an issue");

   // a published result always shows up on the response channel
   a_publish: assert property (@(posedge clock) disable iff (reset)
      ctl.publish |=> rsp_tvalid)
      else $error("published result not presented");

endmodule
